// ----- rtl/hvs_pkg.sv -----
// Shared types, codes and the microprogram of the harmonic Verlet step block.
// No dependencies; every other file of the block depends on this package.
package hvs_pkg;

    // Fixed widths of the interface fields
    localparam int HVS_FIELD_W = 32;
    localparam int HVS_UCFG_W  = 31;
    localparam int HVS_STEP_W  = 16;
    localparam int HVS_CFG_IDX_W = 3;

    // Multiplier operand width (signed 32 bit sign-extended, or unsigned 31 bit zero-extended)
    localparam int HVS_OP_W   = 33;
    // Width of the shifted product and of the saturating adder
    localparam int HVS_WIDE   = 64;

    // Configuration register indexes
    localparam logic [HVS_CFG_IDX_W-1:0] REG_MASS   = 3'd0;
    localparam logic [HVS_CFG_IDX_W-1:0] REG_SPRING = 3'd1;
    localparam logic [HVS_CFG_IDX_W-1:0] REG_DT     = 3'd2;
    localparam logic [HVS_CFG_IDX_W-1:0] REG_HALF   = 3'd3;
    localparam logic [HVS_CFG_IDX_W-1:0] REG_START  = 3'd4;

    // Multiplier operand pairs
    localparam logic [2:0] MOP_NONE = 3'd0;
    localparam logic [2:0] MOP_HF   = 3'd1;
    localparam logic [2:0] MOP_VDT  = 3'd2;
    localparam logic [2:0] MOP_KX   = 3'd3;
    localparam logic [2:0] MOP_VV   = 3'd4;
    localparam logic [2:0] MOP_XX   = 3'd5;
    localparam logic [2:0] MOP_E1M  = 3'd6;
    localparam logic [2:0] MOP_E2K  = 3'd7;

    // Writeback operations on the previous cycle's product
    localparam logic [3:0] WB_NONE    = 4'd0;
    localparam logic [3:0] WB_VEL_ADD = 4'd1;
    localparam logic [3:0] WB_POS_ADD = 4'd2;
    localparam logic [3:0] WB_FRC_NEG = 4'd3;
    localparam logic [3:0] WB_E1      = 4'd4;
    localparam logic [3:0] WB_E2      = 4'd5;
    localparam logic [3:0] WB_KE      = 4'd6;
    localparam logic [3:0] WB_PE      = 4'd7;
    localparam logic [3:0] WB_LOAD    = 4'd8;

    // Program layout
    localparam int HVS_PC_W     = 5;
    localparam int HVS_PROG_LEN = 17;
    localparam logic [HVS_PC_W-1:0] HVS_A_TAIL    = 5'd8;
    localparam logic [HVS_PC_W-1:0] HVS_A_RESTART = 5'd14;

    typedef struct packed {
        logic [HVS_UCFG_W-1:0]         mass;
        logic [HVS_UCFG_W-1:0]         spring;
        logic [HVS_UCFG_W-1:0]         dt;
        logic [HVS_UCFG_W-1:0]         half;
        logic signed [HVS_FIELD_W-1:0] start;
    } hvs_cfg_t;

    typedef struct packed {
        logic [2:0] mop;
        logic [3:0] wb;
        logic       cnt_inc;
    } hvs_dp_ctrl_t;

    typedef struct packed {
        hvs_dp_ctrl_t          dp;
        logic                  emit;
        logic                  jmp;
        logic                  jmp_cond;
        logic [HVS_PC_W-1:0]   target;
    } hvs_uop_t;

    typedef struct packed {
        logic [HVS_STEP_W-1:0]         step;
        logic signed [HVS_FIELD_W-1:0] pos;
        logic signed [HVS_FIELD_W-1:0] vel;
        logic [HVS_UCFG_W-1:0]         ke;
        logic [HVS_UCFG_W-1:0]         pe;
        logic [HVS_UCFG_W-1:0]         total;
    } hvs_dp_stat_t;

    // Microprogram: word c issues a product and writes back the one issued at c-1
    function automatic hvs_uop_t hvs_rom(input logic [HVS_PC_W-1:0] addr);
        hvs_uop_t u;
        u = '0;
        case (addr)
            // tick: v += h*f, branch off for a restart
            5'd0:
            begin
                u.dp.mop  = MOP_HF;
                u.jmp     = 1'b1;
                u.jmp_cond = 1'b1;
                u.target  = HVS_A_RESTART;
            end
            5'd1:
            begin
                u.dp.wb      = WB_VEL_ADD;
                u.dp.cnt_inc = 1'b1;
            end
            // x += v*dt
            5'd2: u.dp.mop = MOP_VDT;
            5'd3: u.dp.wb  = WB_POS_ADD;
            // f = -k*x
            5'd4: u.dp.mop = MOP_KX;
            5'd5: u.dp.wb  = WB_FRC_NEG;
            // v += h*f
            5'd6: u.dp.mop = MOP_HF;
            5'd7: u.dp.wb  = WB_VEL_ADD;
            // energies, shared by tick and restart
            5'd8: u.dp.mop = MOP_VV;
            5'd9:
            begin
                u.dp.mop = MOP_XX;
                u.dp.wb  = WB_E1;
            end
            5'd10:
            begin
                u.dp.mop = MOP_E1M;
                u.dp.wb  = WB_E2;
            end
            5'd11:
            begin
                u.dp.mop = MOP_E2K;
                u.dp.wb  = WB_KE;
            end
            5'd12: u.dp.wb = WB_PE;
            5'd13: u.emit  = 1'b1;
            // restart: load x, clear v and the step count, then f = -k*x
            5'd14: u.dp.wb  = WB_LOAD;
            5'd15: u.dp.mop = MOP_KX;
            5'd16:
            begin
                u.dp.wb  = WB_FRC_NEG;
                u.jmp    = 1'b1;
                u.target = HVS_A_TAIL;
            end
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/hvs_if.sv -----
// Request and record channel interfaces of the harmonic Verlet step block.
// Depends on hvs_pkg for the field widths.
interface hvs_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface hvs_rec_if;
    logic                                   valid;
    logic                                   ready;
    logic [hvs_pkg::HVS_STEP_W-1:0]         step_index;
    logic signed [hvs_pkg::HVS_FIELD_W-1:0] position;
    logic signed [hvs_pkg::HVS_FIELD_W-1:0] velocity;
    logic [hvs_pkg::HVS_UCFG_W-1:0]         kin_energy;
    logic [hvs_pkg::HVS_UCFG_W-1:0]         potential_energy;
    logic [hvs_pkg::HVS_UCFG_W-1:0]         total_energy;

    modport source (output valid, output step_index, output position, output velocity,
                    output kin_energy, output potential_energy, output total_energy,
                    input ready);
    modport sink   (input valid, input step_index, input position, input velocity,
                    input kin_energy, input potential_energy, input total_energy,
                    output ready);
endinterface

// ----- rtl/hvs_datapath.sv -----
// Shared multiplier, saturating writeback and particle state registers.
// Depends on hvs_pkg; driven one control word a cycle by the sequencer.
module hvs_datapath
    import hvs_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  hvs_cfg_t     cfg,
    input  hvs_dp_ctrl_t ctrl,
    output hvs_dp_stat_t stat
);

    localparam int EFF_W = (WORD_WIDTH < HVS_FIELD_W) ? WORD_WIDTH : HVS_FIELD_W;
    localparam logic signed [HVS_WIDE-1:0] SMAX_W =
        $signed((HVS_WIDE'(1) << (EFF_W - 1)) - HVS_WIDE'(1));
    localparam logic signed [HVS_WIDE-1:0] SMIN_W = -SMAX_W - HVS_WIDE'(1);

    logic signed [HVS_FIELD_W-1:0] pos_reg;
    logic signed [HVS_FIELD_W-1:0] vel_reg;
    logic signed [HVS_FIELD_W-1:0] frc_reg;
    logic [HVS_STEP_W-1:0]         step_reg;
    logic [HVS_UCFG_W-1:0]         e1_reg;
    logic [HVS_UCFG_W-1:0]         e2_reg;
    logic [HVS_UCFG_W-1:0]         ke_reg;
    logic [HVS_UCFG_W-1:0]         pe_reg;

    logic signed [HVS_OP_W-1:0]    op_a;
    logic signed [HVS_OP_W-1:0]    op_b;
    logic signed [2*HVS_OP_W-1:0]  prod_reg;
    logic signed [2*HVS_OP_W-1:0]  shifted;
    logic signed [HVS_WIDE-1:0]    wide;
    logic signed [HVS_WIDE-1:0]    sat_in;
    logic signed [HVS_WIDE-1:0]    s_val;
    logic signed [HVS_WIDE-1:0]    u_val;
    logic [HVS_UCFG_W:0]           e_sum;
    logic [HVS_UCFG_W-1:0]         e_total;

    // Select the operand pair for this cycle's product
    always_comb
    begin
        case (ctrl.mop)
            MOP_HF:
            begin
                op_a = $signed({2'b00, cfg.half});
                op_b = $signed({frc_reg[HVS_FIELD_W-1], frc_reg});
            end
            MOP_VDT:
            begin
                op_a = $signed({vel_reg[HVS_FIELD_W-1], vel_reg});
                op_b = $signed({2'b00, cfg.dt});
            end
            MOP_KX:
            begin
                op_a = $signed({2'b00, cfg.spring});
                op_b = $signed({pos_reg[HVS_FIELD_W-1], pos_reg});
            end
            MOP_VV:
            begin
                op_a = $signed({vel_reg[HVS_FIELD_W-1], vel_reg});
                op_b = $signed({vel_reg[HVS_FIELD_W-1], vel_reg});
            end
            MOP_XX:
            begin
                op_a = $signed({pos_reg[HVS_FIELD_W-1], pos_reg});
                op_b = $signed({pos_reg[HVS_FIELD_W-1], pos_reg});
            end
            MOP_E1M:
            begin
                op_a = $signed({2'b00, e1_reg});
                op_b = $signed({2'b00, cfg.mass});
            end
            MOP_E2K:
            begin
                op_a = $signed({2'b00, e2_reg});
                op_b = $signed({2'b00, cfg.spring});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Register the full product
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // Scale down (floor), add, negate or load, then clamp
    always_comb
    begin
        shifted = prod_reg >>> FRAC_BITS;
        wide    = $signed(shifted[HVS_WIDE-1:0]);
        case (ctrl.wb)
            WB_VEL_ADD: sat_in = HVS_WIDE'(vel_reg) + wide;
            WB_POS_ADD: sat_in = HVS_WIDE'(pos_reg) + wide;
            WB_FRC_NEG: sat_in = -wide;
            WB_LOAD:    sat_in = HVS_WIDE'(cfg.start);
            default:    sat_in = wide;
        endcase

        if (sat_in > SMAX_W)
            s_val = SMAX_W;
        else if (sat_in < SMIN_W)
            s_val = SMIN_W;
        else
            s_val = sat_in;

        if (wide > SMAX_W)
            u_val = SMAX_W;
        else if (wide < HVS_WIDE'(0))
            u_val = '0;
        else
            u_val = wide;
    end

    // Update particle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            vel_reg  <= '0;
            frc_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            case (ctrl.wb)
                WB_VEL_ADD: vel_reg <= s_val[HVS_FIELD_W-1:0];
                WB_POS_ADD: pos_reg <= s_val[HVS_FIELD_W-1:0];
                WB_FRC_NEG: frc_reg <= s_val[HVS_FIELD_W-1:0];
                WB_LOAD:
                begin
                    pos_reg <= s_val[HVS_FIELD_W-1:0];
                    vel_reg <= '0;
                end
                default: ;
            endcase
            if (ctrl.wb == WB_LOAD)
                step_reg <= '0;
            else if (ctrl.cnt_inc)
                step_reg <= step_reg + HVS_STEP_W'(1);
        end
    end

    // Hold energy intermediates; halve the final products
    always_ff @(posedge clk)
    begin
        case (ctrl.wb)
            WB_E1: e1_reg <= u_val[HVS_UCFG_W-1:0];
            WB_E2: e2_reg <= u_val[HVS_UCFG_W-1:0];
            WB_KE: ke_reg <= u_val[HVS_UCFG_W:1];
            WB_PE: pe_reg <= u_val[HVS_UCFG_W:1];
            default: ;
        endcase
    end

    // Sum the energies with clamp
    always_comb
    begin
        e_sum = {1'b0, ke_reg} + {1'b0, pe_reg};
        if ({{(HVS_WIDE-HVS_UCFG_W-1){1'b0}}, e_sum} > SMAX_W)
            e_total = SMAX_W[HVS_UCFG_W-1:0];
        else
            e_total = e_sum[HVS_UCFG_W-1:0];
    end

    assign stat.step  = step_reg;
    assign stat.pos   = pos_reg;
    assign stat.vel   = vel_reg;
    assign stat.ke    = ke_reg;
    assign stat.pe    = pe_reg;
    assign stat.total = e_total;

endmodule

// ----- rtl/harmonic_verlet_step.sv -----
// Top level of the harmonic Verlet step block: registers, sequencer, record output.
// Depends on hvs_pkg, hvs_if and hvs_datapath.
//
// Usage: each request on tick_req carries one bit, restart. A restart loads
// start_position, clears velocity and the step count and emits record 0; an
// ordinary request advances the particle one velocity Verlet step and emits
// one record on the record channel with position, velocity and the energies. The
// user must write configuration via cfg_write/cfg_index/cfg_data only while idle;
// the block itself does not enforce this.
//
// A restart runs a shorter path through the microprogram than a step request.
// tick_req.ready rises in the same cycle as the record is loaded, and no new
// request is taken before that. The pace is set by the single shared 33x33
// multiplier and its writeback stage: the eight products of a step form a
// dependent chain that the microprogram issues one after another.
//
// Reset clears the particle state and the step count, loads the register
// defaults and leaves the record channel empty. When the receiver stalls the
// record holds; a following request is accepted and worked on, and it waits
// at its last step until the previous record is taken.
module harmonic_verlet_step
    import hvs_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [HVS_CFG_IDX_W-1:0] cfg_index,
    input  logic [HVS_FIELD_W-1:0]   cfg_data,
    hvs_req_if.sink                  tick_req,
    hvs_rec_if.source                record
);

    hvs_cfg_t              cfg_reg;
    logic [HVS_PC_W-1:0]   pc_reg;
    logic [HVS_PC_W-1:0]   pc_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  restart_reg;
    logic                  rec_valid_reg;
    logic                  rec_valid_next;
    hvs_uop_t              uop;
    hvs_dp_ctrl_t          dp_ctrl;
    hvs_dp_stat_t          stat;
    logic                  accept;
    logic                  hold;
    logic                  emit_fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mass   <= 31'd65536;
            cfg_reg.spring <= 31'd65536;
            cfg_reg.dt     <= 31'd66;
            cfg_reg.half   <= 31'd33;
            cfg_reg.start  <= -32'sd65536;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MASS:   cfg_reg.mass   <= cfg_data[HVS_UCFG_W-1:0];
                REG_SPRING: cfg_reg.spring <= cfg_data[HVS_UCFG_W-1:0];
                REG_DT:     cfg_reg.dt     <= cfg_data[HVS_UCFG_W-1:0];
                REG_HALF:   cfg_reg.half   <= cfg_data[HVS_UCFG_W-1:0];
                REG_START:  cfg_reg.start  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Fetch the control word and decide the handshakes
    always_comb
    begin
        uop       = hvs_rom(pc_reg);
        accept    = tick_req.valid && !busy_reg;
        hold      = uop.emit && rec_valid_reg && !record.ready;
        emit_fire = busy_reg && uop.emit && !hold;
        dp_ctrl   = (busy_reg && !hold) ? uop.dp : '0;
    end

    // Advance the program counter, taking jumps
    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            pc_next   = '0;
            busy_next = 1'b1;
        end
        else if (emit_fire)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && !hold)
        begin
            if (uop.jmp && (!uop.jmp_cond || restart_reg))
                pc_next = uop.target;
            else
                pc_next = pc_reg + HVS_PC_W'(1);
        end
    end

    assign rec_valid_next = emit_fire ? 1'b1 : (record.ready ? 1'b0 : rec_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            busy_reg      <= 1'b0;
            restart_reg   <= 1'b0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            busy_reg      <= busy_next;
            rec_valid_reg <= rec_valid_next;
            if (accept)
                restart_reg <= tick_req.restart;
        end
    end

    // Capture the record
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            record.step_index       <= stat.step;
            record.position         <= stat.pos;
            record.velocity         <= stat.vel;
            record.kin_energy       <= stat.ke;
            record.potential_energy <= stat.pe;
            record.total_energy     <= stat.total;
        end
    end

    assign record.valid   = rec_valid_reg;
    assign tick_req.ready = !busy_reg;

    hvs_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctrl  (dp_ctrl),
        .stat  (stat)
    );

    // Sequencer stays inside the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg < HVS_PC_W'(HVS_PROG_LEN)))
        else $error("sequencer left the program");

    // A released emit step always presents a record
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (record.valid && !busy_reg))
        else $error("emit step did not load the record");

    // A restart record carries step zero
    a_restart_step: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && restart_reg) |=> (record.step_index == '0))
        else $error("restart record has nonzero step index");

    // Total is the sum of the halved energies
    a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
        record.valid |-> ({1'b0, record.total_energy} ==
                          ({1'b0, record.kin_energy} + {1'b0, record.potential_energy})))
        else $error("total energy mismatch");

endmodule
